@@ rtl/core/mhd_conserved_to_primitive_defines.svh @@
// Assertion macros shared by the conversion pipeline
`ifndef MHD_CONSERVED_TO_PRIMITIVE_DEFINES_SVH
`define MHD_CONSERVED_TO_PRIMITIVE_DEFINES_SVH
// Assert that a property holds, with reset disable
`define MHD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assert without reset disable
`define MHD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ rtl/core/mhdc2p_pkg.sv @@
// ----------------------------------------------------------------------------
// mhdc2p_pkg
// Types and constants for the conserved-to-primitive pipeline.
// ----------------------------------------------------------------------------
package mhdc2p_pkg;

    localparam int unsigned DataW   = 32;
    localparam int unsigned CoordW  = 6;
    localparam int unsigned GammaW  = 18;
    localparam int unsigned DivSteps = 48;

    typedef enum logic [2:0] {
        CFG_GAMMA   = 3'd0,
        CFG_FIELD   = 3'd1,
        CFG_X_LOW   = 3'd2,
        CFG_X_HIGH  = 3'd3,
        CFG_Y_LOW   = 3'd4,
        CFG_Y_HIGH  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [GammaW-1:0] gamma_minus_one;
        logic              field_enable;
        logic [CoordW-1:0] x_low;
        logic [CoordW-1:0] x_high;
        logic [CoordW-1:0] y_low;
        logic [CoordW-1:0] y_high;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic              ready;
    } t_hs;

    function automatic logic signed [DataW-1:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] lo;
        logic signed [65:0] hi;
        lo = -66'sd2147483648;
        hi = 66'sd2147483647;
        if (v < lo) begin
            sat32 = lo[DataW-1:0];
        end else if (v > hi) begin
            sat32 = hi[DataW-1:0];
        end else begin
            sat32 = v[DataW-1:0];
        end
    endfunction

endpackage

@@ rtl/core/mhdc2p_div.sv @@
// ----------------------------------------------------------------------------
// mhdc2p_div
// Pipelined restoring divider: (num << 16) / den, truncated, one bit a stage.
// ----------------------------------------------------------------------------
module mhdc2p_div (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [mhdc2p_pkg::DataW-1:0] i_num,
    input  logic signed [mhdc2p_pkg::DataW-1:0] i_den,
    output logic signed [mhdc2p_pkg::DataW-1:0] o_quo
);
    localparam int unsigned N = mhdc2p_pkg::DivSteps;
    localparam int unsigned W = mhdc2p_pkg::DataW;

    logic [N-1:0] r_dvd [0:N];
    logic [W:0]   r_rem [0:N];
    logic [W-1:0] r_dsr [0:N];
    logic         r_neg [0:N];

    logic [W-1:0] num_mag;
    logic [W-1:0] den_mag;

    always_comb begin
        num_mag = i_num[W-1] ? W'(-i_num) : W'(i_num);
        den_mag = i_den[W-1] ? W'(-i_den) : W'(i_den);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dvd[0] <= {num_mag, 16'd0};
            r_rem[0] <= '0;
            r_dsr[0] <= den_mag;
            r_neg[0] <= i_num[W-1] ^ i_den[W-1];
        end
    end

    for (genvar s = 0; s < N; s++) begin : g_step
        logic [W+1:0] trial;
        logic [W+1:0] shifted;
        always_comb begin
            shifted = {r_rem[s], r_dvd[s][N-1]};
            trial   = shifted - {2'b00, r_dsr[s]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dsr[s+1] <= r_dsr[s];
                r_neg[s+1] <= r_neg[s];
                if (!trial[W+1]) begin
                    r_rem[s+1] <= trial[W:0];
                    r_dvd[s+1] <= {r_dvd[s][N-2:0], 1'b1};
                end else begin
                    r_rem[s+1] <= shifted[W:0];
                    r_dvd[s+1] <= {r_dvd[s][N-2:0], 1'b0};
                end
            end
        end
    end

    logic signed [65:0] q_s;
    always_comb begin
        q_s   = r_neg[N] ? -$signed({18'd0, r_dvd[N]}) : $signed({18'd0, r_dvd[N]});
        o_quo = mhdc2p_pkg::sat32(q_s);
    end

endmodule

@@ rtl/core/mhdc2p_press.sv @@
// ----------------------------------------------------------------------------
// mhdc2p_press
// Energy and pressure stages: squares, kinetic and magnetic energy, gamma.
// ----------------------------------------------------------------------------
module mhdc2p_press (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [mhdc2p_pkg::DataW-1:0] i_rho,
    input  logic signed [mhdc2p_pkg::DataW-1:0] i_energy,
    input  logic signed [mhdc2p_pkg::DataW-1:0] i_vx,
    input  logic signed [mhdc2p_pkg::DataW-1:0] i_vy,
    input  logic signed [mhdc2p_pkg::DataW-1:0] i_vz,
    input  logic signed [mhdc2p_pkg::DataW-1:0] i_bx,
    input  logic signed [mhdc2p_pkg::DataW-1:0] i_by,
    input  logic signed [mhdc2p_pkg::DataW-1:0] i_bz,
    input  logic                                i_fon,
    input  logic [mhdc2p_pkg::GammaW-1:0]       i_gamma,
    output logic signed [mhdc2p_pkg::DataW-1:0] o_pressure
);
    // stage A: squares
    logic [63:0] r_v2 [0:2];
    logic [63:0] r_b2 [0:2];
    logic signed [31:0] r_rho_a, r_e_a;
    logic r_fon_a;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v2[0] <= 64'(i_vx * i_vx);
            r_v2[1] <= 64'(i_vy * i_vy);
            r_v2[2] <= 64'(i_vz * i_vz);
            r_b2[0] <= 64'(i_bx * i_bx);
            r_b2[1] <= 64'(i_by * i_by);
            r_b2[2] <= 64'(i_bz * i_bz);
            r_rho_a <= i_rho;
            r_e_a   <= i_energy;
            r_fon_a <= i_fon;
        end
    end

    // stage B: sums and split
    logic [49:0] r_vq;
    logic [49:0] r_mmag;
    logic [31:0] r_ar_b;
    logic        r_neg_b;
    logic signed [31:0] r_e_b;
    logic [65:0] vsum, bsum;
    always_comb begin
        vsum = 66'(r_v2[0]) + 66'(r_v2[1]) + 66'(r_v2[2]);
        bsum = r_fon_a ? (66'(r_b2[0]) + 66'(r_b2[1]) + 66'(r_b2[2])) : 66'd0;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vq    <= vsum[65:16];
            r_mmag  <= 50'(bsum >> 17);
            r_ar_b  <= r_rho_a[31] ? 32'(-r_rho_a) : 32'(r_rho_a);
            r_neg_b <= r_rho_a[31];
            r_e_b   <= r_e_a;
        end
    end

    // stage C: partial products of |rho| * vq
    logic [57:0] r_ph;
    logic [55:0] r_pl;
    logic [49:0] r_mmag_c;
    logic r_neg_c;
    logic signed [31:0] r_e_c;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ph     <= 58'(r_ar_b * r_vq[49:24]);
            r_pl     <= 56'(r_ar_b * r_vq[23:0]);
            r_mmag_c <= r_mmag;
            r_neg_c  <= r_neg_b;
            r_e_c    <= r_e_b;
        end
    end

    // stage D: kinetic energy and clamped difference
    logic signed [48:0] r_diff;
    logic signed [48:0] n_diff;
    logic [66:0] kmag_w;
    logic [61:0] kmag;
    logic signed [68:0] diff_w;
    always_comb begin
        kmag_w = (67'(r_ph) << 7) + 67'(r_pl >> 17);
        kmag   = (kmag_w > (67'd1 << 61)) ? (62'd1 << 61) : kmag_w[61:0];
        diff_w = 69'(r_e_c) - (r_neg_c ? -$signed({7'd0, kmag}) : $signed({7'd0, kmag}))
                 - $signed({19'd0, r_mmag_c});
        if (diff_w < -(69'sd1 <<< 47)) begin
            n_diff = -(49'sd1 <<< 47);
        end else if (diff_w > (69'sd1 <<< 47)) begin
            n_diff = 49'sd1 <<< 47;
        end else begin
            n_diff = diff_w[48:0];
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff <= n_diff;
        end
    end

    // stage E: gamma products
    logic [47:0] dm;
    logic [49:0] r_hi;
    logic [63:0] r_part;
    logic r_dneg;
    always_comb begin
        dm = r_diff[48] ? 48'(-r_diff) : 48'(r_diff);
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hi   <= 50'(dm * i_gamma[17:16]);
            r_part <= 64'(dm * i_gamma[15:0]);
            r_dneg <= r_diff[48];
        end
    end

    // stage F: combine and saturate
    logic [50:0] q;
    logic signed [65:0] p;
    always_comb begin
        q = 51'(r_hi) + 51'(r_part >> 16) + ((r_dneg && (r_part[15:0] != 16'd0)) ? 51'd1 : 51'd0);
        p = r_dneg ? -$signed({15'd0, q}) : $signed({15'd0, q});
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_pressure <= mhdc2p_pkg::sat32(p);
        end
    end

endmodule

@@ rtl/core/mhd_conserved_to_primitive.sv @@
// Pipeline from input beat to output beat: entry register, 49 divider
// stages, 6 energy stages, the last driving the outputs.
// Throughput: one beat per cycle while the output is not stalled.
// The whole pipe advances together and holds when the output is stalled.
// Reset (synchronous, active low) clears valid bits and loads the register
// defaults: gamma-1 = 26214, field on, interior bounds 0 and 63.
// ----------------------------------------------------------------------------
// mhd_conserved_to_primitive
// Conserved to primitive ideal-MHD conversion, one cell per cycle unless the output stalls.
// ----------------------------------------------------------------------------
`include "mhd_conserved_to_primitive_defines.svh"
module mhd_conserved_to_primitive #(
    parameter int unsigned GRID_WIDTH  = 64,
    parameter int unsigned GRID_HEIGHT = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [31:0]                  i_density,
    input  logic signed [31:0]                  i_momentum_x,
    input  logic signed [31:0]                  i_momentum_y,
    input  logic signed [31:0]                  i_momentum_z,
    input  logic signed [31:0]                  i_total_energy,
    input  logic signed [31:0]                  i_field_x_in,
    input  logic signed [31:0]                  i_field_y_in,
    input  logic signed [31:0]                  i_field_z_in,
    input  logic [5:0]                          i_cell_column,
    input  logic [5:0]                          i_cell_row,
    input  logic                                i_cfg_we,
    input  logic [2:0]                          i_cfg_index,
    input  logic [17:0]                         i_cfg_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [31:0]                  o_density_out,
    output logic signed [31:0]                  o_velocity_x,
    output logic signed [31:0]                  o_velocity_y,
    output logic signed [31:0]                  o_velocity_z,
    output logic signed [31:0]                  o_pressure,
    output logic signed [31:0]                  o_field_x_out,
    output logic signed [31:0]                  o_field_y_out,
    output logic signed [31:0]                  o_field_z_out,
    output logic                                o_bad_pressure,
    output logic                                o_zero_density
);
    localparam int unsigned DivLat = mhdc2p_pkg::DivSteps + 1;
    localparam int unsigned PrLat  = 6;
    localparam int unsigned Lat    = DivLat + PrLat;

    mhdc2p_pkg::t_cfg r_cfg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gamma_minus_one <= 18'd26214;
            r_cfg.field_enable    <= 1'b1;
            r_cfg.x_low           <= 6'd0;
            r_cfg.x_high          <= 6'd63;
            r_cfg.y_low           <= 6'd0;
            r_cfg.y_high          <= 6'd63;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mhdc2p_pkg::CFG_GAMMA:  r_cfg.gamma_minus_one <= i_cfg_data;
                mhdc2p_pkg::CFG_FIELD:  r_cfg.field_enable    <= i_cfg_data[0];
                mhdc2p_pkg::CFG_X_LOW:  r_cfg.x_low           <= i_cfg_data[5:0];
                mhdc2p_pkg::CFG_X_HIGH: r_cfg.x_high          <= i_cfg_data[5:0];
                mhdc2p_pkg::CFG_Y_LOW:  r_cfg.y_low           <= i_cfg_data[5:0];
                mhdc2p_pkg::CFG_Y_HIGH: r_cfg.y_high          <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // global pipe enable: advance when the output slot is free or taken
    mhdc2p_pkg::t_hs out_hs;
    logic en;
    assign out_hs.valid = o_valid;
    assign out_hs.ready = i_ready;
    assign en      = !out_hs.valid || out_hs.ready;
    assign o_ready = en;

    logic [Lat:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[Lat-1:0], i_valid};
        end
    end
    assign o_valid = r_vld[Lat];

    // entry register
    logic signed [31:0] r_rho, r_mx, r_my, r_mz, r_e, r_bx, r_by, r_bz;
    logic [5:0] r_col, r_row;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rho <= i_density;   r_mx <= i_momentum_x;
            r_my  <= i_momentum_y; r_mz <= i_momentum_z;
            r_e   <= i_total_energy;
            r_bx  <= i_field_x_in; r_by <= i_field_y_in; r_bz <= i_field_z_in;
            r_col <= i_cell_column; r_row <= i_cell_row;
        end
    end

    logic signed [31:0] qx, qy, qz;
    mhdc2p_div u_div_x (.i_clk, .i_en(en), .i_num(r_mx), .i_den(r_rho), .o_quo(qx));
    mhdc2p_div u_div_y (.i_clk, .i_en(en), .i_num(r_my), .i_den(r_rho), .o_quo(qy));
    mhdc2p_div u_div_z (.i_clk, .i_en(en), .i_num(r_mz), .i_den(r_rho), .o_quo(qz));

    // delay line for side data across the divider
    localparam int unsigned SideW = 32 * 5 + 12 + 1;
    logic [SideW-1:0] r_side [0:DivLat-1];
    logic [SideW-1:0] side_in, side_d;
    assign side_in = {r_rho, r_e, r_bx, r_by, r_bz, r_col, r_row, r_rho == 32'sd0};
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= side_in;
            for (int s = 1; s < DivLat; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end
    assign side_d = r_side[DivLat-1];

    logic signed [31:0] d_rho, d_e, d_bx, d_by, d_bz, vx, vy, vz;
    logic [5:0] d_col, d_row;
    logic d_zero;
    assign {d_rho, d_e, d_bx, d_by, d_bz, d_col, d_row, d_zero} = side_d;
    assign vx = d_zero ? 32'sd0 : qx;
    assign vy = d_zero ? 32'sd0 : qy;
    assign vz = d_zero ? 32'sd0 : qz;

    logic signed [31:0] press;
    mhdc2p_press u_press (
        .i_clk, .i_en(en), .i_rho(d_rho), .i_energy(d_e),
        .i_vx(vx), .i_vy(vy), .i_vz(vz),
        .i_bx(d_bx), .i_by(d_by), .i_bz(d_bz),
        .i_fon(r_cfg.field_enable), .i_gamma(r_cfg.gamma_minus_one),
        .o_pressure(press)
    );

    localparam int unsigned OutW = 32 * 7 + 12 + 1 + 1;
    logic [OutW-1:0] r_o [0:PrLat-1];
    logic [OutW-1:0] o_in;
    logic fon;
    assign fon  = r_cfg.field_enable;
    assign o_in = {d_rho, vx, vy, vz, fon ? d_bx : 32'sd0, fon ? d_by : 32'sd0,
                   fon ? d_bz : 32'sd0, d_col, d_row, d_zero, 1'b0};
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o[0] <= o_in;
            for (int s = 1; s < PrLat; s++) begin
                r_o[s] <= r_o[s-1];
            end
        end
    end

    logic [5:0] f_col, f_row;
    logic f_spare;
    assign {o_density_out, o_velocity_x, o_velocity_y, o_velocity_z, o_field_x_out,
            o_field_y_out, o_field_z_out, f_col, f_row, o_zero_density, f_spare}
           = r_o[PrLat-1];
    assign o_pressure = press;
    assign o_bad_pressure = !f_spare && (press <= 32'sd0)
        && (32'(f_col) < GRID_WIDTH) && (32'(f_row) < GRID_HEIGHT)
        && (f_col > r_cfg.x_low) && (f_col < r_cfg.x_high)
        && (f_row > r_cfg.y_low) && (f_row < r_cfg.y_high);

    `MHD_ASSERT(a_hold_on_stall, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid, "output beat dropped while stalled")
    `MHD_ASSERT(a_zero_vel, i_clk, i_rst_n, o_valid && o_zero_density |-> o_velocity_x == 32'sd0 && o_velocity_y == 32'sd0 && o_velocity_z == 32'sd0, "zero density with nonzero velocity")
    `MHD_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_valid, "valid after reset")

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// Conserved-to-primitive MHD conversion testbench
// Streams grid cells through the converter under random input bursts and
// output stalls. Every accepted cell is converted by an in-bench fixed-point
// model, and each output beat is compared field by field against the oldest
// pending primitive set. Runs several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [2:0] CFG_UNUSED = 3'd6;
    localparam int         IDLE_LIMIT = 5000;
    localparam int         DRAIN_CYCLES = 64;

    typedef struct {
        logic signed [31:0] rho;
        logic signed [31:0] mom [3];
        logic signed [31:0] energy;
        logic signed [31:0] fld [3];
        logic [5:0]         col;
        logic [5:0]         row;
    } t_cell;

    typedef struct {
        logic signed [31:0] rho;
        logic signed [31:0] vel [3];
        logic signed [31:0] pres;
        logic signed [31:0] fld [3];
        logic               bad_p;
        logic               zero_rho;
    } t_prim;

    class primitive_ledger;
        mhdc2p_pkg::t_cfg regs;
        t_prim pending_prims[$];
        int    errors;

        function new();
            errors = 0;
            regs.gamma_minus_one = 18'd26214;
            regs.field_enable    = 1'b1;
            regs.x_low  = 6'd0;
            regs.x_high = 6'd63;
            regs.y_low  = 6'd0;
            regs.y_high = 6'd63;
        endfunction

        function void set_reg(logic [2:0] idx, logic [17:0] val);
            case (idx)
                mhdc2p_pkg::CFG_GAMMA:  regs.gamma_minus_one = val;
                mhdc2p_pkg::CFG_FIELD:  regs.field_enable = val[0];
                mhdc2p_pkg::CFG_X_LOW:  regs.x_low = val[5:0];
                mhdc2p_pkg::CFG_X_HIGH: regs.x_high = val[5:0];
                mhdc2p_pkg::CFG_Y_LOW:  regs.y_low = val[5:0];
                mhdc2p_pkg::CFG_Y_HIGH: regs.y_high = val[5:0];
                default: ;
            endcase
        endfunction

        static function longint sat(longint v);
            if (v < -64'sd2147483648) return -64'sd2147483648;
            if (v > 64'sd2147483647) return 64'sd2147483647;
            return v;
        endfunction

        function t_prim to_primitive(t_cell c);
            t_prim     p;
            longint    rho, v, kin, diff, pr;
            longint unsigned vsq, bsq, vq, hi, lo, ar, kmag, mmag, dm, gh, gl, part, q;
            bit        zero, fon;
            rho  = c.rho;
            zero = (rho == 0);
            fon  = regs.field_enable;
            vsq  = 0;
            bsq  = 0;
            kin  = 0;
            for (int k = 0; k < 3; k++) begin
                v = 0;
                if (!zero) v = sat((longint'(c.mom[k]) * 65536) / rho);
                p.vel[k] = v[31:0];
                vsq += longint'(v * v);
                if (fon) bsq += longint'(longint'(c.fld[k]) * longint'(c.fld[k]));
                p.fld[k] = fon ? c.fld[k] : 32'sd0;
            end
            if (!zero) begin
                vq = vsq >> 16;
                hi = vq >> 24;
                lo = vq & 64'hFFFFFF;
                ar = (rho < 0) ? -rho : rho;
                kmag = ((ar * hi) << 7) + ((ar * lo) >> 17);
                if (kmag > (64'd1 << 61)) kmag = 64'd1 << 61;
                kin = (rho < 0) ? -longint'(kmag) : longint'(kmag);
            end
            mmag = bsq >> 17;
            diff = longint'(c.energy) - kin - longint'(mmag);
            if (diff < -(64'sd1 <<< 47)) diff = -(64'sd1 <<< 47);
            if (diff > (64'sd1 <<< 47)) diff = 64'sd1 <<< 47;
            dm   = (diff < 0) ? -diff : diff;
            gh   = 64'(regs.gamma_minus_one) >> 16;
            gl   = 64'(regs.gamma_minus_one) & 64'hFFFF;
            part = dm * gl;
            q    = dm * gh + (part >> 16);
            if (diff < 0) begin
                if (part & 64'hFFFF) q += 1;
                pr = -longint'(q);
            end else begin
                pr = longint'(q);
            end
            pr       = sat(pr);
            p.pres   = pr[31:0];
            p.rho    = c.rho;
            p.zero_rho = zero;
            p.bad_p  = (pr <= 0) && (c.col > regs.x_low) && (c.col < regs.x_high)
                       && (c.row > regs.y_low) && (c.row < regs.y_high);
            return p;
        endfunction

        function void note_cell(t_cell c);
            pending_prims.push_back(to_primitive(c));
        endfunction

        function void check_primitives(t_prim got);
            t_prim want;
            bit    ok;
            if (pending_prims.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected output beat, rho=%h", got.rho);
                return;
            end
            want = pending_prims.pop_front();
            ok = (want.rho === got.rho) && (want.pres === got.pres)
                 && (want.bad_p === got.bad_p) && (want.zero_rho === got.zero_rho);
            for (int k = 0; k < 3; k++)
                ok &= (want.vel[k] === got.vel[k]) && (want.fld[k] === got.fld[k]);
            if (!ok) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: exp rho=%h v=%h/%h/%h p=%h b=%h/%h/%h bad=%b z=%b",
                             want.rho, want.vel[0], want.vel[1], want.vel[2], want.pres,
                             want.fld[0], want.fld[1], want.fld[2], want.bad_p, want.zero_rho);
                    $display("          got rho=%h v=%h/%h/%h p=%h b=%h/%h/%h bad=%b z=%b",
                             got.rho, got.vel[0], got.vel[1], got.vel[2], got.pres,
                             got.fld[0], got.fld[1], got.fld[2], got.bad_p, got.zero_rho);
                end
            end
        endfunction
    endclass

    logic               i_clk, i_rst_n, i_valid, o_ready, i_ready, o_valid;
    logic signed [31:0] i_density, i_momentum_x, i_momentum_y, i_momentum_z;
    logic signed [31:0] i_total_energy, i_field_x_in, i_field_y_in, i_field_z_in;
    logic [5:0]         i_cell_column, i_cell_row;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_index;
    logic [17:0]        i_cfg_data;
    logic signed [31:0] o_density_out, o_velocity_x, o_velocity_y, o_velocity_z;
    logic signed [31:0] o_pressure, o_field_x_out, o_field_y_out, o_field_z_out;
    logic               o_bad_pressure, o_zero_density;

    primitive_ledger ledger = new();
    int idle_cycles = 0;
    int run_left = 0;
    int stall_left = 0;

    mhd_conserved_to_primitive dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        t_prim got;
        if (i_rst_n && o_valid && i_ready) begin
            got.rho = o_density_out;
            got.vel[0] = o_velocity_x;
            got.vel[1] = o_velocity_y;
            got.vel[2] = o_velocity_z;
            got.pres = o_pressure;
            got.fld[0] = o_field_x_out;
            got.fld[1] = o_field_y_out;
            got.fld[2] = o_field_z_out;
            got.bad_p = o_bad_pressure;
            got.zero_rho = o_zero_density;
            ledger.check_primitives(got);
        end
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles = 0;
        end else if (i_rst_n) begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
        if (run_left > 0) begin
            i_ready <= 1'b1;
            run_left--;
        end else if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left--;
        end else begin
            i_ready <= 1'b1;
            run_left = $urandom_range(1, 40);
            stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
    end

    function automatic logic signed [31:0] rand_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 3))
            0: return w;
            1: return $signed(w) >>> $urandom_range(8, 20);
            2: return $signed(w) >>> $urandom_range(20, 30);
            default: return w;
        endcase
    endfunction

    function automatic t_cell rand_cell();
        t_cell c;
        case ($urandom_range(0, 9))
            0: c.rho = 32'sd0;
            1, 2: c.rho = $signed(32'($urandom_range(1, 32'h40000)));
            3: c.rho = -$signed(32'($urandom_range(1, 32'h40000)));
            default: c.rho = rand_word();
        endcase
        for (int k = 0; k < 3; k++) begin
            c.mom[k] = rand_word();
            c.fld[k] = rand_word();
        end
        c.energy = rand_word();
        c.col = 6'($urandom);
        c.row = 6'($urandom);
        return c;
    endfunction

    function automatic t_cell make_cell(logic signed [31:0] rho, logic signed [31:0] m,
                                        logic signed [31:0] e, logic signed [31:0] b,
                                        logic [5:0] col, logic [5:0] row);
        t_cell c;
        c.rho = rho;
        c.energy = e;
        for (int k = 0; k < 3; k++) begin
            c.mom[k] = m;
            c.fld[k] = b;
        end
        c.col = col;
        c.row = row;
        return c;
    endfunction

    task automatic send_cell(t_cell c);
        i_valid <= 1'b1;
        i_density <= c.rho;
        i_momentum_x <= c.mom[0];
        i_momentum_y <= c.mom[1];
        i_momentum_z <= c.mom[2];
        i_total_energy <= c.energy;
        i_field_x_in <= c.fld[0];
        i_field_y_in <= c.fld[1];
        i_field_z_in <= c.fld[2];
        i_cell_column <= c.col;
        i_cell_row <= c.row;
        do @(posedge i_clk); while (!o_ready);
        ledger.note_cell(c);
    endtask

    task automatic send_random(int count);
        int burst, gap;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            send_cell(rand_cell());
            if (burst > 0) begin
                burst--;
            end else begin
                burst = $urandom_range(1, 30);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        i_valid <= 1'b0;
    endtask

    task automatic drain();
        while (ledger.pending_prims.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [17:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        ledger.set_reg(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_regs(logic [17:0] g, logic f, logic [5:0] xl, logic [5:0] xh,
                             logic [5:0] yl, logic [5:0] yh);
        drain();
        write_reg(mhdc2p_pkg::CFG_GAMMA, g);
        write_reg(mhdc2p_pkg::CFG_FIELD, {17'd0, f});
        write_reg(mhdc2p_pkg::CFG_X_LOW, {12'd0, xl});
        write_reg(mhdc2p_pkg::CFG_X_HIGH, {12'd0, xh});
        write_reg(mhdc2p_pkg::CFG_Y_LOW, {12'd0, yl});
        write_reg(mhdc2p_pkg::CFG_Y_HIGH, {12'd0, yh});
    endtask

    initial begin
        localparam logic signed [31:0] MAXV = 32'sh7FFFFFFF;
        localparam logic signed [31:0] MINV = 32'sh80000000;
        localparam logic signed [31:0] ONE  = 32'sh00010000;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_ready <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= mhdc2p_pkg::CFG_GAMMA;
        i_cfg_data <= '0;
        i_density <= '0;
        i_momentum_x <= '0;
        i_momentum_y <= '0;
        i_momentum_z <= '0;
        i_total_energy <= '0;
        i_field_x_in <= '0;
        i_field_y_in <= '0;
        i_field_z_in <= '0;
        i_cell_column <= '0;
        i_cell_row <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_cell(make_cell(ONE, ONE, ONE, ONE, 6'd5, 6'd5));
        send_cell(make_cell(32'sd0, MAXV, ONE, ONE, 6'd10, 6'd10));
        send_cell(make_cell(32'sd0, MINV, MINV, 32'sd0, 6'd63, 6'd0));
        send_cell(make_cell(32'sd1, MAXV, MAXV, MAXV, 6'd1, 6'd1));
        send_cell(make_cell(-32'sd1, MINV, MINV, MINV, 6'd62, 6'd62));
        send_cell(make_cell(MAXV, MAXV, MAXV, MAXV, 6'd63, 6'd63));
        send_cell(make_cell(MINV, MINV, MAXV, MINV, 6'd0, 6'd0));
        send_cell(make_cell(MINV, MAXV, MINV, MAXV, 6'd30, 6'd30));
        send_cell(make_cell(-ONE, ONE, -ONE, 32'sd0, 6'd20, 6'd40));
        send_cell(make_cell(ONE, 32'sd0, 32'sd0, 32'sd0, 6'd2, 6'd2));
        send_cell(make_cell(ONE <<< 2, ONE, ONE <<< 4, ONE, 6'd33, 6'd17));
        send_random(100);

        load_regs(18'd0, 1'b0, 6'd0, 6'd63, 6'd0, 6'd63);
        send_cell(make_cell(ONE, ONE, MAXV, MAXV, 6'd5, 6'd5));
        send_cell(make_cell(MINV, MAXV, MINV, MINV, 6'd5, 6'd5));
        send_random(100);

        load_regs(18'h3FFFF, 1'b1, 6'd10, 6'd20, 6'd30, 6'd40);
        send_cell(make_cell(ONE, ONE, MAXV, 32'sd0, 6'd15, 6'd35));
        send_cell(make_cell(ONE, ONE, MINV, 32'sd0, 6'd15, 6'd35));
        send_cell(make_cell(ONE, ONE, MINV, 32'sd0, 6'd10, 6'd35));
        send_random(100);

        load_regs(18'd131072, 1'b0, 6'd63, 6'd0, 6'd63, 6'd0);
        write_reg(CFG_UNUSED, 18'h3FFFF);
        send_random(100);

        load_regs(18'd26214, 1'b1, 6'd0, 6'd63, 6'd0, 6'd63);
        write_reg(CFG_UNUSED + 3'd1, 18'h15555);
        send_random(120);

        drain();
        if (ledger.errors == 0 && ledger.pending_prims.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
